[src/gfti_pkg.sv]
// Package: types, widths and register indexes shared by the gyro integrator.
package gfti_pkg;

    localparam int MAX_BURST  = 16;
    localparam int MAX_BURSTS = 64;

    localparam int CNT_W  = 11;
    localparam int BC_W   = $clog2(MAX_BURSTS + 1);
    localparam int CFG_DW = 20;
    localparam int CFG_AW = 3;

    // register indexes on the configuration port
    localparam logic [CFG_AW-1:0] CFG_CLIP_THRESH    = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_BURSTS_PER_OUT = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_SAMPLE_PERIOD  = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_OFFSET_X       = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_OFFSET_Y       = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_OFFSET_Z       = 3'd5;

    localparam logic [15:0] CLIP_THRESH_RST = 16'd32767;
    localparam logic [6:0]  BURSTS_RST      = 7'd4;
    localparam logic [14:0] PERIOD_RST      = 15'd125;

    typedef struct packed {
        logic signed [15:0] sample_x;
        logic signed [15:0] sample_y;
        logic signed [15:0] sample_z;
        logic [4:0]         burst_length;
        logic               last_in_burst;
        logic [47:0]        timestamp_us;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] delta_x;
        logic signed [31:0] delta_y;
        logic signed [31:0] delta_z;
        logic [10:0]        sample_total;
        logic [24:0]        span_us;
        logic [10:0]        clips_x;
        logic [10:0]        clips_y;
        logic [10:0]        clips_z;
        logic [31:0]        clip_total_x;
        logic [31:0]        clip_total_y;
        logic [31:0]        clip_total_z;
    } out_item_t;

endpackage

[src/gyro_fifo_trapezoid_integrator_core.sv]
// Top level: trapezoidal delta-angle integrator for three-axis gyro samples.
// Path: input register, then the result register (m_valid) for a closing request.
// Throughput: one request per cycle; the only stall is a result-producing request held
//   in the input register while the previous result has not been taken.
// Reset (aresetn low, synchronous): registers go to their defaults, all sums, counts,
//   clip totals and the last-sample history clear, and both channels empty.
module gyro_fifo_trapezoid_integrator_core
    import gfti_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    // configuration write port
    input  logic              cfg_wr_en,
    input  logic [CFG_AW-1:0] cfg_index,
    input  logic [CFG_DW-1:0] cfg_wdata,
    // sample requests
    input  logic              s_valid,
    output logic              s_ready,
    input  in_item_t          s_data,
    // integrated results
    output logic              m_valid,
    input  logic              m_ready,
    output out_item_t         m_data
);

    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [BC_W-1:0]  BC_MAX  = '1;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [15:0]        clip_thresh_reg;
    logic [6:0]         bursts_per_out_reg;
    logic [14:0]        sample_period_reg;
    logic signed [19:0] offset_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clip_thresh_reg    <= CLIP_THRESH_RST;
            bursts_per_out_reg <= BURSTS_RST;
            sample_period_reg  <= PERIOD_RST;
            for (int i = 0; i < 3; i++) begin
                offset_reg[i] <= '0;
            end
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_CLIP_THRESH:    clip_thresh_reg    <= cfg_wdata[15:0];
                CFG_BURSTS_PER_OUT: bursts_per_out_reg <= cfg_wdata[6:0];
                CFG_SAMPLE_PERIOD:  sample_period_reg  <= cfg_wdata[14:0];
                CFG_OFFSET_X:       offset_reg[0]      <= $signed(cfg_wdata);
                CFG_OFFSET_Y:       offset_reg[1]      <= $signed(cfg_wdata);
                CFG_OFFSET_Z:       offset_reg[2]      <= $signed(cfg_wdata);
                default: ;  // indexes beyond the map are ignored
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Input register: one request deep, refills in the cycle it drains
    // ---------------------------------------------------------------
    logic     in_valid_reg;
    in_item_t in_reg;
    logic     advance;    // request in in_reg is processed this cycle
    logic     emit;       // that request closes an output interval
    logic     out_free;

    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
    end

    // ---------------------------------------------------------------
    // Integrator state
    // acc_reg holds the trapezoid sum in half-LSB units: inner samples
    // add twice, the burst's last sample and the previous burst's last
    // sample add once each.
    // ---------------------------------------------------------------
    logic signed [31:0] acc_reg       [3];
    logic [CNT_W-1:0]   int_clips_reg [3];
    logic [31:0]        life_clips_reg [3];
    logic signed [15:0] prev_last_reg [3];
    logic [BC_W-1:0]    burst_count_reg;
    logic [CNT_W-1:0]   sample_count_reg;
    logic [47:0]        prev_ts_reg;
    logic               mid_burst_reg;

    logic signed [31:0] acc_next       [3];
    logic [CNT_W-1:0]   int_clips_next [3];
    logic [31:0]        life_clips_next [3];
    logic [BC_W-1:0]    burst_count_next;
    logic [CNT_W-1:0]   sample_count_next;

    logic signed [15:0] smp [3];
    logic               last;
    logic [4:0]         len_clamp;
    logic [20:0]        gap_thr;
    logic [47:0]        ts_diff;
    logic               gap_clear;
    logic [BC_W-1:0]    target;

    logic signed [31:0] acc_base   [3];
    logic [CNT_W-1:0]   clips_base [3];
    logic [BC_W-1:0]    bc_base;
    logic [CNT_W-1:0]   sc_base;

    logic [16:0]        sx17       [3];
    logic [16:0]        mag        [3];
    logic               clipped    [3];
    logic signed [17:0] addend     [3];
    logic signed [32:0] acc_sum    [3];
    logic signed [31:0] offs_prod  [3];
    logic signed [35:0] delta_wide [3];
    logic signed [31:0] delta_sat  [3];
    logic [25:0]        span_wide;
    logic [24:0]        span_sat;

    assign smp[0] = in_reg.sample_x;
    assign smp[1] = in_reg.sample_y;
    assign smp[2] = in_reg.sample_z;
    assign last   = in_reg.last_in_burst;

    always_comb begin
        // gap detection on the first sample of a burst
        if (in_reg.burst_length == 5'd0) begin
            len_clamp = 5'd1;
        end else if (32'(in_reg.burst_length) > MAX_BURST) begin
            len_clamp = 5'(MAX_BURST);
        end else begin
            len_clamp = in_reg.burst_length;
        end
        gap_thr   = {20'(sample_period_reg) * 20'(len_clamp), 1'b0};
        ts_diff   = in_reg.timestamp_us - prev_ts_reg;
        gap_clear = !mid_burst_reg && (in_reg.timestamp_us > prev_ts_reg)
                    && (ts_diff > 48'(gap_thr));

        bc_base = gap_clear ? '0 : burst_count_reg;
        sc_base = gap_clear ? '0 : sample_count_reg;
        sample_count_next = (sc_base == CNT_MAX) ? sc_base : sc_base + 1'b1;
        burst_count_next  = bc_base;
        if (last && bc_base != BC_MAX) begin
            burst_count_next = bc_base + 1'b1;
        end

        if (bursts_per_out_reg == 7'd0) begin
            target = BC_W'(1);
        end else if (32'(bursts_per_out_reg) > MAX_BURSTS) begin
            target = BC_W'(MAX_BURSTS);
        end else begin
            target = BC_W'(bursts_per_out_reg);
        end
        emit = last && (burst_count_next >= target);

        for (int i = 0; i < 3; i++) begin
            acc_base[i]   = gap_clear ? '0 : acc_reg[i];
            clips_base[i] = gap_clear ? '0 : int_clips_reg[i];

            // magnitude of -32768 is 32768, hence 17 bits
            sx17[i]    = {smp[i][15], smp[i]};
            mag[i]     = smp[i][15] ? (~sx17[i] + 17'd1) : sx17[i];
            clipped[i] = mag[i] >= {1'b0, clip_thresh_reg};

            int_clips_next[i] = clips_base[i];
            if (clipped[i] && clips_base[i] != CNT_MAX) begin
                int_clips_next[i] = clips_base[i] + 1'b1;
            end
            life_clips_next[i] = life_clips_reg[i];
            if (clipped[i] && life_clips_reg[i] != 32'hFFFF_FFFF) begin
                life_clips_next[i] = life_clips_reg[i] + 32'd1;
            end

            if (last) begin
                addend[i] = 18'(prev_last_reg[i]) + 18'(smp[i]);
            end else begin
                addend[i] = {smp[i][15], smp[i], 1'b0};
            end
            acc_sum[i] = 33'(acc_base[i]) + 33'(addend[i]);
            if (acc_sum[i][32] != acc_sum[i][31]) begin
                acc_next[i] = acc_sum[i][32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            end else begin
                acc_next[i] = acc_sum[i][31:0];
            end

            // 1/16 LSB: acc (half LSB) times 8, less bias per sample
            offs_prod[i]  = 32'(offset_reg[i]) * 32'($signed({1'b0, sample_count_next}));
            delta_wide[i] = {acc_next[i][31], acc_next[i], 3'b000} - 36'(offs_prod[i]);
            if (delta_wide[i][35:31] != {5{delta_wide[i][35]}}) begin
                delta_sat[i] = delta_wide[i][35] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            end else begin
                delta_sat[i] = delta_wide[i][31:0];
            end
        end

        span_wide = 26'(sample_count_next) * 26'(sample_period_reg);
        span_sat  = span_wide[25] ? '1 : span_wide[24:0];
    end

    assign out_free = !m_valid || m_ready;
    assign advance  = in_valid_reg && (!emit || out_free);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                acc_reg[i]        <= '0;
                int_clips_reg[i]  <= '0;
                life_clips_reg[i] <= '0;
                prev_last_reg[i]  <= '0;
            end
            burst_count_reg  <= '0;
            sample_count_reg <= '0;
            prev_ts_reg      <= '0;
            mid_burst_reg    <= 1'b0;
        end else if (advance) begin
            for (int i = 0; i < 3; i++) begin
                life_clips_reg[i] <= life_clips_next[i];
                if (last) begin
                    prev_last_reg[i] <= smp[i];
                end
                // a result closes the interval
                acc_reg[i]       <= emit ? '0 : acc_next[i];
                int_clips_reg[i] <= emit ? '0 : int_clips_next[i];
            end
            burst_count_reg  <= emit ? '0 : burst_count_next;
            sample_count_reg <= emit ? '0 : sample_count_next;
            if (last) begin
                prev_ts_reg <= in_reg.timestamp_us;
            end else if (gap_clear) begin
                prev_ts_reg <= '0;
            end
            mid_burst_reg <= !last;
        end
    end

    // ---------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------
    logic      m_valid_reg;
    out_item_t m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance && emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && emit) begin
            m_data_reg.delta_x      <= delta_sat[0];
            m_data_reg.delta_y      <= delta_sat[1];
            m_data_reg.delta_z      <= delta_sat[2];
            m_data_reg.sample_total <= sample_count_next;
            m_data_reg.span_us      <= span_sat;
            m_data_reg.clips_x      <= int_clips_next[0];
            m_data_reg.clips_y      <= int_clips_next[1];
            m_data_reg.clips_z      <= int_clips_next[2];
            m_data_reg.clip_total_x <= life_clips_next[0];
            m_data_reg.clip_total_y <= life_clips_next[1];
            m_data_reg.clip_total_z <= life_clips_next[2];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_emit_loads_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && emit) |=> m_valid)
        else $error("result not loaded after closing request");

    a_emit_clears_interval: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && emit) |=> (sample_count_reg == '0 && burst_count_reg == '0))
        else $error("interval not cleared after result");

    a_mid_burst_has_samples: assert property (@(posedge aclk) disable iff (!aresetn)
        mid_burst_reg |-> (sample_count_reg != '0))
        else $error("open burst with empty interval");

    a_burst_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(burst_count_reg) < MAX_BURSTS)
        else $error("burst count reached output target without a result");

    a_last_closes_burst: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && last) |=> !mid_burst_reg)
        else $error("burst still open after its last sample");

endmodule
